FILE: rtl/core/rasm_pkg.sv
`timescale 1ns / 1ps

package rasm_pkg;

  // Operand and result widths fixed by the item format.
  localparam int unsigned OPERAND_BITS = 30;
  localparam int unsigned MODREG_BITS  = 10;
  localparam int unsigned WEIGHT_BITS  = 30;
  localparam int unsigned RANGE_BITS   = 31;
  localparam int unsigned MAX_MODULI   = 3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MODULUS_0   = 3'd0;
  localparam logic [2:0] CFG_MODULUS_1   = 3'd1;
  localparam logic [2:0] CFG_MODULUS_2   = 3'd2;
  localparam logic [2:0] CFG_WEIGHT_0    = 3'd3;
  localparam logic [2:0] CFG_WEIGHT_1    = 3'd4;
  localparam logic [2:0] CFG_WEIGHT_2    = 3'd5;
  localparam logic [2:0] CFG_RANGE       = 3'd6;

  // Operation codes as they arrive on the input side.
  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_MUL  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // One queued work item.
  typedef struct packed {
    op_t                     op;
    logic [OPERAND_BITS-1:0] a;
    logic [OPERAND_BITS-1:0] b;
  } item_t;

endpackage

FILE: rtl/core/rasm_front.sv
`timescale 1ns / 1ps

module rasm_front (
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [63:0]          s_tdata,
  input  logic [1:0]           s_tuser,
  output logic                 push_valid,
  input  logic                 push_ready,
  output rasm_pkg::item_t      push_item
);

  // Unpack the operands and decode the operation into its kind.
  always_comb begin
    push_item.a = s_tdata[29:0];
    push_item.b = s_tdata[59:30];
    unique case (s_tuser)
      2'd0:    push_item.op = rasm_pkg::OP_ADD;
      2'd1:    push_item.op = rasm_pkg::OP_SUB;
      2'd2:    push_item.op = rasm_pkg::OP_MUL;
      default: push_item.op = rasm_pkg::OP_NONE;
    endcase
  end

  // The queue takes a transfer whenever it has room.
  assign push_valid = s_tvalid;
  assign s_tready   = push_ready;

endmodule

FILE: rtl/core/rasm_fifo.sv
`timescale 1ns / 1ps

module rasm_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  rasm_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output rasm_pkg::item_t pop_item
);

  rasm_pkg::item_t mem [4];
  logic [1:0]      wr_ptr;
  logic [1:0]      rd_ptr;
  logic [2:0]      count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != 3'd4);
  assign pop_valid  = (count != 3'd0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage for queued items.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      if (do_push && !do_pop) begin
        count <= count + 3'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 3'd1;
      end
    end
  end

endmodule

FILE: rtl/core/rasm_mod_pipe.sv
`timescale 1ns / 1ps

// Restoring remainder, one dividend bit per stage. A zero modulus never
// subtracts, so the output is then the low MW bits of the dividend.
module rasm_mod_pipe #(
  parameter int unsigned DW = 30,
  parameter int unsigned MW = 10
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] din,
  input  logic [MW-1:0] m,
  output logic [MW-1:0] dout
);

  logic [DW-1:0][DW-1:0] dat;
  logic [DW-1:0][MW-1:0] rem;

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [DW-1:0] d_in;
    logic [MW-1:0] r_in;
    logic [MW:0]   sh;
    logic [MW-1:0] r_nx;

    if (k == 0) begin : g_first
      assign d_in = din;
      assign r_in = '0;
    end else begin : g_rest
      assign d_in = dat[k-1];
      assign r_in = rem[k-1];
    end

    // Shift in the next bit and subtract the modulus once if it fits.
    assign sh   = {r_in, d_in[DW-1-k]};
    assign r_nx = ((m != '0) && (sh >= {1'b0, m})) ? MW'(sh - {1'b0, m}) : sh[MW-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        dat[k] <= d_in;
        rem[k] <= r_nx;
      end
    end
  end

  assign dout = rem[DW-1];

endmodule

FILE: rtl/core/rasm_back.sv
`timescale 1ns / 1ps

module rasm_back #(
  parameter int unsigned NUM_MODULI   = 3,
  parameter int unsigned MODULUS_BITS = 10
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  rasm_pkg::item_t                        in_item,
  input  logic [2:0][rasm_pkg::MODREG_BITS-1:0]  moduli,
  input  logic [2:0][rasm_pkg::WEIGHT_BITS-1:0]  weights,
  input  logic [rasm_pkg::RANGE_BITS-1:0]        range_val,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [rasm_pkg::OPERAND_BITS-1:0]      out_value
);

  localparam int unsigned OB   = rasm_pkg::OPERAND_BITS;
  localparam int unsigned MB   = MODULUS_BITS;
  localparam int unsigned PB   = rasm_pkg::WEIGHT_BITS + MB;
  localparam int unsigned SW   = PB + 2;
  localparam int unsigned RB   = rasm_pkg::RANGE_BITS;
  localparam int unsigned LAT  = OB + 1 + 2 * MB + 1 + 1 + SW;

  logic                        en;
  logic [LAT-1:0]              vld;
  rasm_pkg::op_t               opd [OB];
  logic [NUM_MODULI-1:0][PB-1:0] prod;
  logic [SW-1:0]               sum_r;
  logic [SW-1:0]               sum_c;
  logic [RB-1:0]               rem_out;

  // The whole pipe advances unless a finished result is held.
  assign en        = !vld[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // Carry the operation alongside the operand reduction.
  always_ff @(posedge clk) begin
    if (en) begin
      opd[0] <= in_item.op;
      for (int k = 1; k < OB; k++) begin
        opd[k] <= opd[k-1];
      end
    end
  end

  for (genvar i = 0; i < NUM_MODULI; i++) begin : g_lane
    logic [MB-1:0]   m;
    logic [MB-1:0]   ra;
    logic [MB-1:0]   rb;
    logic [2*MB-1:0] c_nx;
    logic [2*MB-1:0] c_r;
    logic [MB-1:0]   rc;
    logic [MB-1:0]   res;

    assign m = MB'(moduli[i]);

    rasm_mod_pipe #(.DW(OB), .MW(MB)) u_ra (
      .clk(clk), .en(en), .din(in_item.a), .m(m), .dout(ra)
    );
    rasm_mod_pipe #(.DW(OB), .MW(MB)) u_rb (
      .clk(clk), .en(en), .din(in_item.b), .m(m), .dout(rb)
    );

    // Combine residues; the sum, difference or product is reduced next.
    always_comb begin
      unique case (opd[OB-1])
        rasm_pkg::OP_ADD: c_nx = (2*MB)'(ra) + (2*MB)'(rb);
        rasm_pkg::OP_SUB: c_nx = (2*MB)'(ra) + (2*MB)'(m) - (2*MB)'(rb);
        rasm_pkg::OP_MUL: c_nx = ra * rb;
        default:          c_nx = '0;
      endcase
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_r <= c_nx;
      end
    end

    rasm_mod_pipe #(.DW(2 * MB), .MW(MB)) u_rc (
      .clk(clk), .en(en), .din(c_r), .m(m), .dout(rc)
    );

    // A zero modulus yields a zero residue.
    assign res = (m == '0) ? '0 : rc;

    // Weighted residue for the reconstruction.
    always_ff @(posedge clk) begin
      if (en) begin
        prod[i] <= weights[i] * res;
      end
    end
  end

  // Sum the weighted residues.
  always_comb begin
    sum_c = '0;
    for (int i = 0; i < NUM_MODULI; i++) begin
      sum_c = sum_c + SW'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_c;
    end
  end

  // Final reduction by the dynamic range; zero range keeps low sum bits.
  rasm_mod_pipe #(.DW(SW), .MW(RB)) u_range (
    .clk(clk), .en(en), .din(sum_r), .m(range_val), .dout(rem_out)
  );

  assign out_value = rem_out[OB-1:0];

endmodule

FILE: rtl/core/rns_add_sub_mult_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Signals                           Contents
// s_        in   s_tvalid s_tready s_tdata s_tuser operation, operand_a, operand_b
// m_        out  m_tvalid m_tready m_tdata         result_value
// cfg_      in   cfg_valid cfg_ready cfg_index ...  register writes
//
// One item per cycle is accepted while the input queue has room. A result
// passes through the queue and the bit-serial remainder stages (operands,
// combined residue and dynamic range). Reset is synchronous and empties the
// queue and the pipeline. A stalled output freezes the pipeline; the
// four-entry input queue keeps taking transfers until it fills.
module rns_add_sub_mult_unit #(
  parameter int unsigned NUM_MODULI   = 3,
  parameter int unsigned MODULUS_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // operand_a [29:0], operand_b [59:30], zero pad
  input  logic [1:0]  s_tuser,   // operation [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // result_value [29:0], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  logic [2:0][rasm_pkg::MODREG_BITS-1:0] moduli;
  logic [2:0][rasm_pkg::WEIGHT_BITS-1:0] weights;
  logic [rasm_pkg::RANGE_BITS-1:0]       range_val;
  logic                                  push_valid;
  logic                                  push_ready;
  rasm_pkg::item_t                       push_item;
  logic                                  pop_valid;
  logic                                  pop_ready;
  rasm_pkg::item_t                       pop_item;
  logic [rasm_pkg::OPERAND_BITS-1:0]     result;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      moduli    <= {10'd9, 10'd8, 10'd7};
      weights   <= {30'd280, 30'd441, 30'd288};
      range_val <= 31'd504;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rasm_pkg::CFG_MODULUS_0: moduli[0]  <= cfg_data[9:0];
        rasm_pkg::CFG_MODULUS_1: moduli[1]  <= cfg_data[9:0];
        rasm_pkg::CFG_MODULUS_2: moduli[2]  <= cfg_data[9:0];
        rasm_pkg::CFG_WEIGHT_0:  weights[0] <= cfg_data[29:0];
        rasm_pkg::CFG_WEIGHT_1:  weights[1] <= cfg_data[29:0];
        rasm_pkg::CFG_WEIGHT_2:  weights[2] <= cfg_data[29:0];
        rasm_pkg::CFG_RANGE:     range_val  <= cfg_data;
        default: ;
      endcase
    end
  end

  rasm_front u_front (
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .push_valid(push_valid), .push_ready(push_ready), .push_item(push_item)
  );

  rasm_fifo u_fifo (
    .clk(clk), .rst(rst),
    .push_valid(push_valid), .push_ready(push_ready), .push_item(push_item),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_item(pop_item)
  );

  rasm_back #(.NUM_MODULI(NUM_MODULI), .MODULUS_BITS(MODULUS_BITS)) u_back (
    .clk(clk), .rst(rst),
    .in_valid(pop_valid), .in_ready(pop_ready), .in_item(pop_item),
    .moduli(moduli), .weights(weights), .range_val(range_val),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_value(result)
  );

  assign m_tdata = {2'b00, result};

endmodule

FILE: tb/rns_add_sub_mult_checker.sv
`timescale 1ns / 1ps

module rns_add_sub_mult_checker #(
  parameter int unsigned NUM_MODULI   = 3,
  parameter int unsigned MODULUS_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          results_seen
);

  localparam int unsigned OB = rasm_pkg::OPERAND_BITS;

  // Shadow copy of the register file.
  logic [rasm_pkg::MODREG_BITS-1:0] moduli [rasm_pkg::MAX_MODULI];
  logic [rasm_pkg::WEIGHT_BITS-1:0] weights [rasm_pkg::MAX_MODULI];
  logic [rasm_pkg::RANGE_BITS-1:0]  range_q;

  // Predicted results in order, kept in a ring with running counters.
  logic [OB-1:0] expected_results [1024];
  int            wr_cnt;
  int            rd_cnt;
  logic [OB-1:0] expected_head;

  assign pending       = wr_cnt - rd_cnt;
  assign expected_head = expected_results[rd_cnt[9:0]];

  // Residue arithmetic followed by the CRT weighted sum.
  function automatic logic [OB-1:0] rns_result(rasm_pkg::op_t op,
                                               logic [63:0] a,
                                               logic [63:0] b);
    logic [63:0] sum;
    logic [63:0] m;
    logic [63:0] ra;
    logic [63:0] rb;
    logic [63:0] r;
    sum = 0;
    for (int i = 0; i < NUM_MODULI && i < rasm_pkg::MAX_MODULI; i++) begin
      m = 64'(moduli[i]) & ((64'd1 << MODULUS_BITS) - 1);
      ra = (m == 0) ? 64'd0 : a % m;
      rb = (m == 0) ? 64'd0 : b % m;
      case (op)
        rasm_pkg::OP_ADD: r = (m == 0) ? 64'd0 : (ra + rb) % m;
        rasm_pkg::OP_SUB: r = (m == 0) ? 64'd0 : (ra + m - rb) % m;
        rasm_pkg::OP_MUL: r = (m == 0) ? 64'd0 : (ra * rb) % m;
        default: r = 0;
      endcase
      sum += 64'(weights[i]) * r;
    end
    if (range_q != 0) sum = sum % 64'(range_q);
    return sum[OB-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      moduli[0] <= 10'd7;
      moduli[1] <= 10'd8;
      moduli[2] <= 10'd9;
      weights[0] <= 30'd288;
      weights[1] <= 30'd441;
      weights[2] <= 30'd280;
      range_q <= 31'd504;
      mismatches <= 0;
      results_seen <= 0;
      wr_cnt <= 0;
      rd_cnt <= 0;
    end else begin
      // Register write transfer.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rasm_pkg::CFG_MODULUS_0: moduli[0] <= cfg_data[rasm_pkg::MODREG_BITS-1:0];
          rasm_pkg::CFG_MODULUS_1: moduli[1] <= cfg_data[rasm_pkg::MODREG_BITS-1:0];
          rasm_pkg::CFG_MODULUS_2: moduli[2] <= cfg_data[rasm_pkg::MODREG_BITS-1:0];
          rasm_pkg::CFG_WEIGHT_0: weights[0] <= cfg_data[rasm_pkg::WEIGHT_BITS-1:0];
          rasm_pkg::CFG_WEIGHT_1: weights[1] <= cfg_data[rasm_pkg::WEIGHT_BITS-1:0];
          rasm_pkg::CFG_WEIGHT_2: weights[2] <= cfg_data[rasm_pkg::WEIGHT_BITS-1:0];
          rasm_pkg::CFG_RANGE: range_q <= cfg_data;
          default: ;
        endcase
      end
      // Input transfer: predict its result.
      if (s_tvalid && s_tready) begin
        expected_results[wr_cnt[9:0]] <= rns_result(rasm_pkg::op_t'(s_tuser),
                                                     {34'd0, s_tdata[29:0]},
                                                     {34'd0, s_tdata[59:30]});
        wr_cnt <= wr_cnt + 1;
      end
      // Output transfer: compare with the oldest prediction.
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (wr_cnt == rd_cnt) begin
          if (mismatches < 10) $display("unexpected result %0d", m_tdata[29:0]);
          mismatches <= mismatches + 1;
        end else begin
          if (m_tdata[29:0] !== expected_head || m_tdata[31:30] !== 2'b00) begin
            if (mismatches < 10)
              $display("result mismatch: expected %0d, got %0d (raw %h)",
                       expected_head, m_tdata[29:0], m_tdata);
            mismatches <= mismatches + 1;
          end
          rd_cnt <= rd_cnt + 1;
        end
      end
    end
  end

endmodule

FILE: tb/rns_add_sub_mult_unit_test.sv
`timescale 1ns / 1ps

module rns_add_sub_mult_unit_test;

  localparam int DRAIN_CYCLES = 200;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [30:0] cfg_data;
  int          mismatches;
  int          pending;
  int          results_seen;
  int          items_sent;
  bit          calm;
  bit          long_hold;

  rns_add_sub_mult_unit i_dut (.*);

  rns_add_sub_mult_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("rns_add_sub_mult_unit: mismatch");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off, none near the end.
  // The long hold-off outlasts the pipeline depth so the input queue fills.
  initial begin
    int hold;
    m_tready = 0;
    @(posedge clk iff !rst);
    forever begin
      if (long_hold) begin
        m_tready <= 0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end else if (!calm && $urandom_range(3) == 0) begin
        hold = $urandom_range(9, 1);
        m_tready <= 0;
        repeat (hold) @(posedge clk);
      end else begin
        m_tready <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [30:0] value);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic load_set(logic [30:0] m0, logic [30:0] m1, logic [30:0] m2,
                          logic [30:0] w0, logic [30:0] w1, logic [30:0] w2,
                          logic [30:0] dr);
    write_reg(rasm_pkg::CFG_MODULUS_0, m0);
    write_reg(rasm_pkg::CFG_MODULUS_1, m1);
    write_reg(rasm_pkg::CFG_MODULUS_2, m2);
    write_reg(rasm_pkg::CFG_WEIGHT_0, w0);
    write_reg(rasm_pkg::CFG_WEIGHT_1, w1);
    write_reg(rasm_pkg::CFG_WEIGHT_2, w2);
    write_reg(rasm_pkg::CFG_RANGE, dr);
    write_reg(3'd7, 31'h7fffffff);
  endtask

  task automatic send_op(rasm_pkg::op_t op, logic [29:0] a, logic [29:0] b);
    if (!calm && $urandom_range(4) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(9, 1)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {4'd0, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic finish_phase();
    s_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [29:0] rand_operand();
    case ($urandom_range(3))
      0: return 30'($urandom_range(20));
      1: return 30'h3fffffff - 30'($urandom_range(5));
      default: return 30'($urandom);
    endcase
  endfunction

  task automatic random_items(int count);
    for (int k = 0; k < count; k++)
      send_op(rasm_pkg::op_t'($urandom_range(3)), rand_operand(), rand_operand());
  endtask

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tdata = 0;
    s_tuser = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    items_sent = 0;
    calm = 0;
    long_hold = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed items on the reset setting: extremes and every operation.
    for (int o = 0; o < 4; o++) begin
      send_op(rasm_pkg::op_t'(o), 30'd0, 30'd0);
      send_op(rasm_pkg::op_t'(o), 30'h3fffffff, 30'h3fffffff);
      send_op(rasm_pkg::op_t'(o), 30'd3, 30'h3fffffff);
      send_op(rasm_pkg::op_t'(o), 30'h2aaaaaaa, 30'h15555555);
    end
    send_op(rasm_pkg::OP_SUB, 30'd1, 30'd5);
    send_op(rasm_pkg::OP_MUL, 30'd503, 30'd503);
    finish_phase();

    // Fill the input queue while the output is held off.
    long_hold = 1;
    random_items(150);
    finish_phase();

    // Largest coprime moduli with large weights and range.
    load_set(1021, 1022, 1023, 1046529, 1066738, 533715, 1067431086);
    random_items(250);
    finish_phase();

    // Zero moduli, unreduced sum and over-wide range.
    load_set(0, 1, 1023, 30'h3fffffff, 30'h3fffffff, 30'h3fffffff, 0);
    random_items(200);
    finish_phase();

    load_set(2, 3, 0, 30'h3fffffff, 30'h2aaaaaaa, 30'h15555555, 31'h7fffffff);
    random_items(150);
    finish_phase();

    // Random register contents, range set to eight.
    load_set(31'($urandom_range(1023)), 31'($urandom_range(1023)),
             31'($urandom_range(1023)), 31'($urandom), 31'($urandom), 31'($urandom), 8);
    random_items(150);
    finish_phase();

    load_set(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom),
             31'($urandom), 31'($urandom), 31'($urandom));
    random_items(100);
    calm = 1;
    random_items(130);
    finish_phase();

    $display("Sent %0d items over six register settings, %0d results checked.",
             items_sent, results_seen);
    if (mismatches == 0) begin
      $display("rns_add_sub_mult_unit: match");
    end else begin
      $display("rns_add_sub_mult_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/rasm_pkg.sv
rtl/core/rasm_front.sv
rtl/core/rasm_fifo.sv
rtl/core/rasm_mod_pipe.sv
rtl/core/rasm_back.sv
rtl/core/rns_add_sub_mult_unit.sv
tb/rns_add_sub_mult_checker.sv
tb/rns_add_sub_mult_unit_test.sv
